[rtl/bfc_pkg.sv]
`timescale 1ns / 1ps

package bfc_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEVEL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW_MS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS   = 2'd3;

    localparam logic [15:0] RST_DEBOUNCE_MS     = 16'd20;
    localparam logic [15:0] RST_CLICK_WINDOW_MS = 16'd250;
    localparam logic [15:0] RST_LONG_PRESS_MS   = 16'd1000;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic        invert_level;
        logic [15:0] debounce_ms;
        logic [15:0] click_window_ms;
        logic [15:0] long_press_ms;
    } t_cfg;

    typedef struct packed {
        logic        func;
        logic [31:0] now_ms;
        logic        raw_level;
        logic [31:0] query_ms;
    } t_item;

    typedef struct packed {
        logic        is_down;
        logic        went_down;
        logic        went_up;
        logic [7:0]  click_total;
        logic [31:0] held_total_ms;
        logic [31:0] change_time_ms;
        logic        held_for_query;
        logic        up_for_query;
    } t_result;

endpackage

[rtl/bfc_cfg.sv]
`timescale 1ns / 1ps

module bfc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_cfg_ready,
    output bfc_pkg::t_cfg                 o_cfg
);
    import bfc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert_level    <= 1'b0;
            r_cfg.debounce_ms     <= RST_DEBOUNCE_MS;
            r_cfg.click_window_ms <= RST_CLICK_WINDOW_MS;
            r_cfg.long_press_ms   <= RST_LONG_PRESS_MS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INVERT_LEVEL:    r_cfg.invert_level    <= i_cfg_data[0];
                CFG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_cfg_data;
                CFG_CLICK_WINDOW_MS: r_cfg.click_window_ms <= i_cfg_data;
                CFG_LONG_PRESS_MS:   r_cfg.long_press_ms   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

[rtl/bfc_in_reg.sv]
`timescale 1ns / 1ps

module bfc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  bfc_pkg::t_item i_item,
    output logic           o_in_ready,
    input  logic           i_take,
    output logic           o_valid,
    output bfc_pkg::t_item o_item
);
    import bfc_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  w_ready;

    assign w_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_in_valid) begin
            r_item <= i_item;
        end
    end

    assign o_in_ready = w_ready;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

endmodule

[rtl/bfc_core.sv]
`timescale 1ns / 1ps

module bfc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bfc_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  bfc_pkg::t_item   i_item,
    output logic             o_take,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bfc_pkg::t_result o_result
);
    import bfc_pkg::*;

    logic        r_level;
    logic [31:0] r_sample_time;
    logic [31:0] r_change_time;
    logic [7:0]  r_pub;
    logic [7:0]  r_run;
    logic [31:0] r_held;
    logic        r_out_valid;
    t_result     r_result;

    logic        n_level;
    logic [31:0] n_sample_time;
    logic [31:0] n_change_time;
    logic [7:0]  n_pub;
    logic [7:0]  n_run;
    logic [31:0] n_held;
    t_result     n_result;

    logic        w_lvl;
    logic [31:0] w_since;
    logic [31:0] w_since_new;
    logic        w_pass;
    logic        w_edge;
    logic        w_stable;
    logic        w_take;

    assign w_take = !r_out_valid || i_out_ready;

    always_comb begin
        w_lvl         = i_item.raw_level ^ i_cfg.invert_level;
        w_since       = i_item.now_ms - r_change_time;
        w_pass        = w_since > {16'd0, i_cfg.debounce_ms};
        w_edge        = w_pass && (w_lvl != r_level);
        w_since_new   = w_edge ? 32'd0 : w_since;
        n_level       = r_level;
        n_sample_time = r_sample_time;
        n_change_time = r_change_time;
        n_pub         = r_pub;
        n_run         = r_run;
        n_held        = r_held;
        w_stable      = (r_sample_time - r_change_time) >= i_item.query_ms;
        if (i_item.func == FUNC_SAMPLE) begin
            n_level       = w_pass ? w_lvl : r_level;
            n_sample_time = i_item.now_ms;
            n_change_time = w_edge ? i_item.now_ms : r_change_time;
            if (w_edge && n_level) begin
                n_held = 32'd0;
                n_run  = r_run + 8'd1;
            end
            if (!n_level && (w_since_new > {16'd0, i_cfg.click_window_ms})) begin
                n_pub = n_run;
                n_run = 8'd0;
            end
            if (n_level && (w_since_new > {16'd0, i_cfg.long_press_ms})) begin
                n_pub = 8'd0;
                n_run = 8'd0;
            end
            if (n_level) begin
                n_held = n_held + (i_item.now_ms - r_sample_time);
            end
            w_stable = w_since_new >= i_item.query_ms;
        end else begin
            n_pub  = 8'd0;
            n_run  = 8'd0;
            n_held = 32'd0;
        end
        n_result.is_down        = n_level;
        n_result.went_down      = (i_item.func == FUNC_SAMPLE) && w_edge && n_level;
        n_result.went_up        = (i_item.func == FUNC_SAMPLE) && w_edge && !n_level;
        n_result.click_total    = n_pub;
        n_result.held_total_ms  = n_held;
        n_result.change_time_ms = n_change_time;
        n_result.held_for_query = n_level && w_stable;
        n_result.up_for_query   = !n_level && w_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level       <= 1'b0;
            r_sample_time <= 32'd0;
            r_change_time <= 32'd0;
            r_pub         <= 8'd0;
            r_run         <= 8'd0;
            r_held        <= 32'd0;
            r_out_valid   <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                r_level       <= n_level;
                r_sample_time <= n_sample_time;
                r_change_time <= n_change_time;
                r_pub         <= n_pub;
                r_run         <= n_run;
                r_held        <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_take      = w_take;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

`ifndef SYNTH
    a_down_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.went_down |-> r_result.is_down)
        else $error("press edge reported while released");

    a_up_edge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.went_up |-> !r_result.is_down)
        else $error("release edge reported while pressed");

    a_state_tracks_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.is_down == r_level) &&
                        (r_result.change_time_ms == r_change_time))
        else $error("result register out of step with state");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && i_valid && (i_item.func == FUNC_CLEAR) |=>
            (r_pub == 8'd0) && (r_run == 8'd0) && (r_held == 32'd0))
        else $error("clear request left counts set");
`endif

endmodule

[rtl/button_debounce_click_counter_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// in        in         i_in_valid / o_in_ready    i_func, i_now_ms, i_raw_level, i_query_ms
// out       out        o_out_valid / i_out_ready  o_is_down .. o_up_for_query
//
// One request per cycle sustained unless the output stalls; a taken request passes the
// input register, then the result register with the button state update, to the output.
// Synchronous active-low reset: button released at time 0, counts zero, config defaults.
// A stalled output holds its result; the input register still takes one more request.
// Config writes are always ready and take effect on the next cycle.

module button_debounce_click_counter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [31:0]                   i_now_ms,
    input  logic                          i_raw_level,
    input  logic [31:0]                   i_query_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_is_down,
    output logic                          o_went_down,
    output logic                          o_went_up,
    output logic [7:0]                    o_click_total,
    output logic [31:0]                   o_held_total_ms,
    output logic [31:0]                   o_change_time_ms,
    output logic                          o_held_for_query,
    output logic                          o_up_for_query
);
    import bfc_pkg::*;

    t_cfg    w_cfg;
    t_item   w_in_item;
    t_item   w_s1_item;
    logic    w_s1_valid;
    logic    w_take;
    t_result w_result;

    assign w_in_item.func      = i_func;
    assign w_in_item.now_ms    = i_now_ms;
    assign w_in_item.raw_level = i_raw_level;
    assign w_in_item.query_ms  = i_query_ms;

    bfc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    bfc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (w_in_item),
        .o_in_ready (o_in_ready),
        .i_take     (w_take),
        .o_valid    (w_s1_valid),
        .o_item     (w_s1_item)
    );

    bfc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (w_s1_valid),
        .i_item      (w_s1_item),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_is_down        = w_result.is_down;
    assign o_went_down      = w_result.went_down;
    assign o_went_up        = w_result.went_up;
    assign o_click_total    = w_result.click_total;
    assign o_held_total_ms  = w_result.held_total_ms;
    assign o_change_time_ms = w_result.change_time_ms;
    assign o_held_for_query = w_result.held_for_query;
    assign o_up_for_query   = w_result.up_for_query;

endmodule
